/* sv/heartbeat_membership_table_assert.svh */
// Assertion macros for the heartbeat membership table.
`ifndef HEARTBEAT_MEMBERSHIP_TABLE_ASSERT_SVH
`define HEARTBEAT_MEMBERSHIP_TABLE_ASSERT_SVH
`ifndef SYNTH
`define HMT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HMT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/hmt_pkg.sv */
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared constants and types of the heartbeat membership table.
// ----------------------------------------------------------------------------
package hmt_pkg;
  localparam int unsigned TableEntriesDef = 16;

  localparam logic [1:0] FuncMerge  = 2'd0;
  localparam logic [1:0] FuncTick   = 2'd1;
  localparam logic [1:0] FuncList   = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [1:0] KindMerge   = 2'd0;
  localparam logic [1:0] KindRemoved = 2'd1;
  localparam logic [1:0] KindList    = 2'd2;
  localparam logic [1:0] KindNone    = 2'd3;

  localparam logic [1:0] StRefreshed = 2'd0;
  localparam logic [1:0] StKnown     = 2'd1;
  localparam logic [1:0] StAdded     = 2'd2;
  localparam logic [1:0] StFull      = 2'd3;

  localparam logic [1:0] RegSelfId    = 2'd0;
  localparam logic [1:0] RegSelfPort  = 2'd1;
  localparam logic [1:0] RegFailAge   = 2'd2;
  localparam logic [1:0] RegRemoveAge = 2'd3;

  localparam int unsigned EntryW = 112; // id, port, heartbeat, time

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] tm;
  } entry_t;
endpackage

/* sv/heartbeat_membership_table.sv */
// Merge result and last tick/list beat follow a scan of all TABLE_ENTRIES
// slots, one slot read per cycle (list with self_only: no scan).
// Commands are accepted only while not busy (self_only list and unused code
// never set it); busy drops in the cycle the last beat is driven. Receiver cannot stall.
// Reset (rst_n low, synchronous) clears all slot valid bits, own heartbeat
// and config to defaults; the entry RAM needs no clearing.
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// Gossip membership table: merge, tick sweep and list over a slot RAM.
// ----------------------------------------------------------------------------
`include "heartbeat_membership_table_assert.svh"
module heartbeat_membership_table #(
  parameter int unsigned TABLE_ENTRIES = hmt_pkg::TableEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_peer_id,
  input  logic [15:0] in_peer_port,
  input  logic [31:0] in_peer_heartbeat,
  input  logic [31:0] in_now,
  input  logic        in_self_only,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_merge_status,
  output logic [31:0] out_entry_id,
  output logic [15:0] out_entry_port,
  output logic [31:0] out_entry_heartbeat,
  output logic        out_last
);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LastSlot = CW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1; // walk slots, data arrives next cycle
  localparam logic [2:0] S_FIN  = 3'd2; // merge finish / tick none / list end
  localparam logic [2:0] S_WR   = 3'd3; // unused; merge writes back in S_FIN

  logic [2:0] state_r, state_nxt;
  logic [31:0] self_id_r, fail_age_r, remove_age_r, own_hb_r;
  logic [15:0] self_port_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [1:0]  func_r;
  logic [31:0] pid_r, phb_r, now_r;
  logic [15:0] pport_r;

  logic [CW-1:0] rd_cnt_r;       // address issued
  logic          rd_pend_r;      // data valid this cycle for slot rd_slot_r
  logic [AW-1:0] rd_slot_r;
  logic          hit_r, free_ok_r, any_r;
  logic [AW-1:0] hit_slot_r, free_slot_r;
  hmt_pkg::entry_t hit_ent_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  hmt_pkg::entry_t ram_wdata, ram_rdata;

  hmt_ram #(.Width(hmt_pkg::EntryW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign ram_raddr = rd_cnt_r[AW-1:0];

  logic accept;
  assign accept = start && !busy;

  logic [31:0] age;
  logic        slot_v, match, stale_rm, stale_fail;
  assign age        = now_r - ram_rdata.tm;
  assign slot_v     = rd_pend_r && valid_r[rd_slot_r];
  assign match      = slot_v && ram_rdata.id == pid_r && ram_rdata.port == pport_r;
  assign stale_rm   = slot_v && (age > remove_age_r);
  assign stale_fail = age > fail_age_r;

  logic scan_done;
  assign scan_done = (rd_cnt_r == CW'(TABLE_ENTRIES));
  logic last_data;
  assign last_data = rd_pend_r && (rd_slot_r == LastSlot[AW-1:0]);

  // output register
  logic        ov_nxt, ol_nxt;
  logic [1:0]  ok_nxt, os_nxt;
  logic [31:0] oid_nxt, ohb_nxt;
  logic [15:0] op_nxt;
  logic        newer;
  assign newer = hit_ent_r.hb < phb_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = 1'b0; ol_nxt = 1'b0; ok_nxt = hmt_pkg::KindMerge;
    os_nxt = hmt_pkg::StRefreshed; oid_nxt = '0; op_nxt = '0; ohb_nxt = '0;
    ram_we = 1'b0; ram_waddr = hit_slot_r; ram_wdata = hit_ent_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_func == hmt_pkg::FuncList) begin
            ov_nxt = 1'b1; ok_nxt = hmt_pkg::KindList;
            oid_nxt = self_id_r; op_nxt = self_port_r; ohb_nxt = own_hb_r;
            ol_nxt = in_self_only;
            state_nxt = in_self_only ? S_IDLE : S_SCAN;
          end else if (in_func == hmt_pkg::FuncMerge || in_func == hmt_pkg::FuncTick) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (func_r == hmt_pkg::FuncTick && stale_rm) begin
          ov_nxt = 1'b1; ok_nxt = hmt_pkg::KindRemoved;
          oid_nxt = ram_rdata.id; op_nxt = ram_rdata.port; ohb_nxt = ram_rdata.hb;
        end
        if (func_r == hmt_pkg::FuncList && slot_v) begin
          ov_nxt = 1'b1; ok_nxt = hmt_pkg::KindList;
          if (stale_fail) begin
            oid_nxt = self_id_r; op_nxt = self_port_r; ohb_nxt = own_hb_r;
          end else begin
            oid_nxt = ram_rdata.id; op_nxt = ram_rdata.port; ohb_nxt = ram_rdata.hb;
          end
        end
        if (last_data) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        if (func_r == hmt_pkg::FuncMerge) begin
          ov_nxt = 1'b1; ol_nxt = 1'b1; ok_nxt = hmt_pkg::KindMerge;
          priority if (hit_r) begin
            oid_nxt = hit_ent_r.id; op_nxt = hit_ent_r.port;
            if (newer) begin
              os_nxt = hmt_pkg::StRefreshed; ohb_nxt = phb_r;
              ram_we = 1'b1; ram_waddr = hit_slot_r;
              ram_wdata = '{id: hit_ent_r.id, port: hit_ent_r.port, hb: phb_r, tm: now_r};
            end else begin
              os_nxt = hmt_pkg::StKnown; ohb_nxt = hit_ent_r.hb;
            end
          end else if (free_ok_r) begin
            os_nxt = hmt_pkg::StAdded;
            oid_nxt = pid_r; op_nxt = pport_r; ohb_nxt = phb_r;
            ram_we = 1'b1; ram_waddr = free_slot_r;
            ram_wdata = '{id: pid_r, port: pport_r, hb: phb_r, tm: now_r};
          end else begin
            os_nxt = hmt_pkg::StFull;
            oid_nxt = pid_r; op_nxt = pport_r; ohb_nxt = phb_r;
          end
        end else if (func_r == hmt_pkg::FuncTick) begin
          // last removed beat is flagged on release from hold; emit none marker otherwise
          if (!any_r) begin
            ov_nxt = 1'b1; ol_nxt = 1'b1; ok_nxt = hmt_pkg::KindNone;
          end
        end
      end
      S_WR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Tick and list: the final beat is only known once the scan ends, so the
  // output is held one stage (hold_*) and its last flag patched on release.
  logic        hold_v_r, hold_l_r;
  logic [1:0]  hold_k_r, hold_s_r;
  logic [31:0] hold_id_r, hold_hb_r;
  logic [15:0] hold_p_r;
  logic        final_beat;
  assign final_beat = (state_r == S_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      self_id_r <= 32'd1; self_port_r <= 16'd0;
      fail_age_r <= 32'd5; remove_age_r <= 32'd20;
      own_hb_r <= '0; valid_r <= '0;
      rd_cnt_r <= '0; rd_pend_r <= 1'b0;
      hold_v_r <= 1'b0; out_valid <= 1'b0;
      hit_r <= 1'b0; free_ok_r <= 1'b0; any_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hmt_pkg::RegSelfId:    self_id_r <= cfg_data;
          hmt_pkg::RegSelfPort:  self_port_r <= cfg_data[15:0];
          hmt_pkg::RegFailAge:   fail_age_r <= cfg_data;
          hmt_pkg::RegRemoveAge: remove_age_r <= cfg_data;
        endcase
      end
      if (accept) begin
        rd_cnt_r <= '0; rd_pend_r <= 1'b0;
        hit_r <= 1'b0; free_ok_r <= 1'b0; any_r <= 1'b0;
        if (in_func == hmt_pkg::FuncTick) own_hb_r <= own_hb_r + 32'd1;
      end else if (state_r == S_SCAN) begin
        rd_pend_r <= !scan_done;
        rd_slot_r <= rd_cnt_r[AW-1:0];
        if (!scan_done) rd_cnt_r <= rd_cnt_r + CW'(1);
        if (func_r == hmt_pkg::FuncMerge && rd_pend_r) begin
          if (match && !hit_r) begin
            hit_r <= 1'b1; hit_slot_r <= rd_slot_r; hit_ent_r <= ram_rdata;
          end
          if (!valid_r[rd_slot_r] && !free_ok_r) begin
            free_ok_r <= 1'b1; free_slot_r <= rd_slot_r;
          end
        end
        if (func_r == hmt_pkg::FuncTick && stale_rm) begin
          valid_r[rd_slot_r] <= 1'b0; any_r <= 1'b1;
        end
      end
      if (state_r == S_FIN && func_r == hmt_pkg::FuncMerge && !hit_r && free_ok_r) begin
        valid_r[free_slot_r] <= 1'b1;
      end
      // hold stage
      if (ov_nxt && !(state_r == S_FIN)) begin
        hold_v_r <= !ol_nxt;
      end else if (final_beat) begin
        hold_v_r <= 1'b0;
      end
      if (ov_nxt && ol_nxt && state_r == S_IDLE) begin
        out_valid <= 1'b1;
      end else if (ov_nxt && state_r != S_FIN) begin
        out_valid <= hold_v_r;
      end else if (final_beat) begin
        out_valid <= hold_v_r || ov_nxt;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func; pid_r <= in_peer_id; pport_r <= in_peer_port;
      phb_r <= in_peer_heartbeat; now_r <= in_now;
    end
    // shift: new beat into hold, old hold to the port
    if (ov_nxt && state_r == S_IDLE && ol_nxt) begin
      out_result_kind <= ok_nxt; out_merge_status <= os_nxt;
      out_entry_id <= oid_nxt; out_entry_port <= op_nxt;
      out_entry_heartbeat <= ohb_nxt; out_last <= 1'b1;
    end else if ((ov_nxt && state_r != S_FIN) || (final_beat && hold_v_r)) begin
      out_result_kind <= hold_k_r; out_merge_status <= hold_s_r;
      out_entry_id <= hold_id_r; out_entry_port <= hold_p_r;
      out_entry_heartbeat <= hold_hb_r; out_last <= final_beat;
    end else if (final_beat) begin
      out_result_kind <= ok_nxt; out_merge_status <= os_nxt;
      out_entry_id <= oid_nxt; out_entry_port <= op_nxt;
      out_entry_heartbeat <= ohb_nxt; out_last <= 1'b1;
    end
    if (ov_nxt && state_r != S_FIN) begin
      hold_k_r <= ok_nxt; hold_s_r <= os_nxt; hold_id_r <= oid_nxt;
      hold_p_r <= op_nxt; hold_hb_r <= ohb_nxt; hold_l_r <= ol_nxt;
    end
  end

  `HMT_ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_ready, state_r == S_IDLE, "cfg while busy")
  `HMT_ASSERT_NEXT(a_fin_idle, clk, rst_n, state_r == S_FIN, state_r == S_IDLE, "fin stuck")
  `HMT_ASSERT_IMPL(a_hold_scan, clk, rst_n, hold_v_r && !hold_l_r, busy, "hold out of op")
  `HMT_ASSERT_NEXT(a_merge_one, clk, rst_n, state_r == S_FIN && func_r == hmt_pkg::FuncMerge,
    out_valid && out_last, "merge result missing")
endmodule

/* sv/hmt_ram.sv */
// ----------------------------------------------------------------------------
// hmt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                           wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                           rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
